/* src/tmcg_pkg.sv */
// ----------------------------------------------------------------------------
// tmcg_pkg: shared types and constants for the text-mode character generator
// Request kinds, configuration register indexes, default screen geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcg_pkg;

  localparam int unsigned TEXT_COLS_DEF  = 180;
  localparam int unsigned TEXT_ROWS_DEF  = 60;
  localparam int unsigned GLYPH_ROWS_DEF = 16;
  localparam int unsigned GLYPH_COLS     = 8;

  localparam int unsigned FONT_AW    = 12;
  localparam int unsigned FONT_DEPTH = 1 << FONT_AW;
  localparam int unsigned PIX_W      = 4;

  localparam logic [7:0] CURSOR_COL_RST   = 8'd1;
  localparam logic [5:0] CURSOR_ROW_RST   = 6'd1;
  localparam logic [3:0] CURSOR_FIRST_RST = 4'd14;
  localparam logic [3:0] CURSOR_LAST_RST  = 4'd15;
  localparam logic [7:0] BLINK_PERIOD_RST = 8'd16;
  localparam logic [7:0] TICK_MAX         = 8'hFF;

  typedef enum logic [1:0] {
    REQ_FONT_WR = 2'd0,
    REQ_CELL    = 2'd1,
    REQ_TICK    = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    CFG_CURSOR_COL   = 3'd0,
    CFG_CURSOR_ROW   = 3'd1,
    CFG_CURSOR_FIRST = 3'd2,
    CFG_CURSOR_LAST  = 3'd3,
    CFG_BLINK_PERIOD = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

/* src/text_mode_character_generator_core.sv */
// ----------------------------------------------------------------------------
// text_mode_character_generator_core: 8x16 text-mode scan-out
// Turns character cells in raster order into eight 4-bit pixels per cell,
// with a font RAM loaded over the input stream and a blinking block cursor.
//
// Usage:
//   in_*  : requests. tuser is the request kind (font byte write, character
//           cell, frame tick); tdata carries font address/byte and the cell's
//           code/attribute. Only character cells produce an output transfer.
//   out_* : one transfer per cell, tdata = 32-bit pixel word (leftmost pixel
//           in the top nibble), tlast set on the last cell of the frame.
//   cfg_* : register writes (cursor position, cursor lines, blink period),
//           which the user must apply only while the stream is idle;
//           the core does not enforce this.
// Throughput is one request per cycle; when out_tready is low the output
// register and the read stage fill up and in_tready drops; nothing is lost.
// A cell passes the synchronous font RAM read, then the output register. The
// font RAM is not cleared; glyphs must be loaded before use. Reset restores
// the register defaults, clears the scan counters, tick count and blink phase.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_character_generator_core
  import tmcg_pkg::*;
#(
  parameter int unsigned TEXT_COLS  = TEXT_COLS_DEF,
  parameter int unsigned TEXT_ROWS  = TEXT_ROWS_DEF,
  parameter int unsigned GLYPH_ROWS = GLYPH_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [11:0] font_addr, [19:12] font_byte, [27:20] char_code,
  // [35:28] attribute, [39:36] zero
  input  wire logic [39:0] in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  in_tuser,

  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] pixels
  output logic [31:0]      out_tdata,
  output logic             out_tlast,     // frame_end

  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  // input fields
  logic [FONT_AW-1:0] font_addr;
  logic [7:0]         font_byte;
  logic [7:0]         char_code;
  logic [7:0]         attribute;
  req_type_t          req;

  assign font_addr = in_tdata[11:0];
  assign font_byte = in_tdata[19:12];
  assign char_code = in_tdata[27:20];
  assign attribute = in_tdata[35:28];
  assign req       = req_type_t'(in_tuser);

  // configuration
  logic [7:0] cursor_col_r;
  logic [5:0] cursor_row_r;
  logic [3:0] cursor_first_r;
  logic [3:0] cursor_last_r;
  logic [7:0] blink_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r   <= CURSOR_COL_RST;
      cursor_row_r   <= CURSOR_ROW_RST;
      cursor_first_r <= CURSOR_FIRST_RST;
      cursor_last_r  <= CURSOR_LAST_RST;
      blink_period_r <= BLINK_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_CURSOR_COL:   cursor_col_r   <= cfg_wdata;
        CFG_CURSOR_ROW:   cursor_row_r   <= cfg_wdata[5:0];
        CFG_CURSOR_FIRST: cursor_first_r <= cfg_wdata[3:0];
        CFG_CURSOR_LAST:  cursor_last_r  <= cfg_wdata[3:0];
        CFG_BLINK_PERIOD: blink_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic in_xfer;
  logic cell_xfer;
  logic font_wr;
  logic tick_xfer;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign cell_xfer = in_xfer && (req == REQ_CELL);
  assign font_wr   = in_xfer && (req == REQ_FONT_WR);
  assign tick_xfer = in_xfer && (req == REQ_TICK);

  // scan position, tick count, blink phase
  logic [7:0] col_r, col_nxt;
  logic [3:0] line_r, line_nxt;
  logic [5:0] row_r, row_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic       phase_r, phase_nxt;

  logic       frame_start;
  logic       col_wrap;
  logic       line_wrap;
  logic       row_wrap;
  logic       hit;
  logic       last;

  always_comb begin
    frame_start = (col_r == '0) && (line_r == '0) && (row_r == '0);
    col_wrap    = ({1'b0, col_r} + 9'd1) >= 9'(TEXT_COLS);
    line_wrap   = ({1'b0, line_r} + 5'd1) >= 5'(GLYPH_ROWS);
    row_wrap    = ({1'b0, row_r} + 7'd1) >= 7'(TEXT_ROWS);
    last        = col_wrap && line_wrap && row_wrap;

    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    col_nxt   = col_r;
    line_nxt  = line_r;
    row_nxt   = row_r;

    if (tick_xfer && (tick_r != TICK_MAX)) begin
      tick_nxt = tick_r + 8'd1;
    end

    if (cell_xfer) begin
      // blink check happens at frame start, before the cell is drawn
      if (frame_start && (tick_r >= blink_period_r)) begin
        tick_nxt  = '0;
        phase_nxt = !phase_r;
      end
      if (col_wrap) begin
        col_nxt = '0;
        if (line_wrap) begin
          line_nxt = '0;
          row_nxt  = row_wrap ? '0 : row_r + 6'd1;
        end else begin
          line_nxt = line_r + 4'd1;
        end
      end else begin
        col_nxt = col_r + 8'd1;
      end
    end

    hit = phase_nxt
          && (({1'b0, col_r} + 9'd1) == {1'b0, cursor_col_r})
          && (({1'b0, row_r} + 7'd1) == {1'b0, cursor_row_r})
          && (line_r >= cursor_first_r)
          && (line_r <= cursor_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      line_r  <= '0;
      row_r   <= '0;
      tick_r  <= '0;
      phase_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      line_r  <= line_nxt;
      row_r   <= row_nxt;
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
    end
  end

  // font RAM: one write port, one registered read port
  logic [7:0]         font_mem [FONT_DEPTH];
  logic [FONT_AW-1:0] rd_addr;
  logic [7:0]         glyph_r;

  assign rd_addr = FONT_AW'({4'b0, char_code} * FONT_AW'(GLYPH_ROWS))
                   + FONT_AW'(line_r);

  always_ff @(posedge clk) begin
    if (font_wr) begin
      font_mem[font_addr] <= font_byte;
    end
    if (cell_xfer) begin
      glyph_r <= font_mem[rd_addr];
    end
  end

  // read stage: cell attributes wait for the RAM data
  logic [3:0] fg_r;
  logic [3:0] bg_r;
  logic       hit_r;
  logic       last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= cell_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_xfer) begin
      fg_r   <= attribute[3:0];
      bg_r   <= attribute[7:4];
      hit_r  <= hit;
      last_r <= last;
    end
  end

  // pixel expansion
  logic [31:0] pix_word;

  always_comb begin
    for (int i = 0; i < GLYPH_COLS; i++) begin
      pix_word[i*PIX_W +: PIX_W] = (hit_r || glyph_r[i]) ? fg_r : bg_r;
    end
  end

  // output register
  logic [31:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= pix_word;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
